FILE: rtl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared types and character codes for the integer to decimal text block.
// ----------------------------------------------------------------------------
package s2d_pkg;

    typedef logic [5:0] t_char;

    localparam t_char ASCII_ZERO  = 6'h30;
    localparam t_char ASCII_MINUS = 6'h2D;

endpackage

FILE: rtl/s2d_value_if.sv
// ----------------------------------------------------------------------------
// s2d_value_if
// Valid/ready channel carrying one signed integer.
// ----------------------------------------------------------------------------
interface s2d_value_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/s2d_char_if.sv
// ----------------------------------------------------------------------------
// s2d_char_if
// Valid/ready channel carrying the low six bits of one ASCII character and an end-of-text flag.
// ----------------------------------------------------------------------------
interface s2d_char_if;
    logic           valid;
    logic           ready;
    s2d_pkg::t_char character;
    logic           last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer in, decimal ASCII text out, most significant digit first.
// ----------------------------------------------------------------------------
// Each integer becomes a run of characters: an optional '-', then the digits
// with leading zeros dropped ('0' for zero); the final character has last set.
// The sign/magnitude register and VALUE_WIDTH double-dabble steps form a
// pipeline that takes a value every cycle unless the sequencer holds it back;
// a value passes the input register and each step register in turn on its way
// to the character sequencer. The sequencer sets the sustained rate: it walks
// NDIG digit positions per value, NDIG being the decimal digit count of the
// widest magnitude, takes no new value before the current one is done, and
// accepts the next while the last character still waits in the output register.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2d_value_if.sink   i_in,
    s2d_char_if.source  o_out
);
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

    logic                   r_in_valid;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   r_neg;

    logic                   st_valid [VALUE_WIDTH+1];
    logic                   st_ready [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] st_bin   [VALUE_WIDTH+1];
    logic [4*NDIG-1:0]      st_bcd   [VALUE_WIDTH+1];
    logic                   st_neg   [VALUE_WIDTH+1];

    assign i_in.ready = !r_in_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            // unsigned magnitude, so the most negative value is exact
            r_mag <= i_in.value[VALUE_WIDTH-1] ? (~i_in.value + 1'b1) : i_in.value;
            r_neg <= i_in.value[VALUE_WIDTH-1];
        end
    end

    assign st_valid[0] = r_in_valid;
    assign st_bin[0]   = r_mag;
    assign st_bcd[0]   = '0;
    assign st_neg[0]   = r_neg;

    for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_step
        s2d_dabble_step #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .NDIG        (NDIG)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_bin   (st_bin[g]),
            .i_bcd   (st_bcd[g]),
            .i_neg   (st_neg[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_bin   (st_bin[g+1]),
            .o_bcd   (st_bcd[g+1]),
            .o_neg   (st_neg[g+1])
        );
    end

    s2d_emitter #(
        .NDIG (NDIG)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[VALUE_WIDTH]),
        .o_ready (st_ready[VALUE_WIDTH]),
        .i_bcd   (st_bcd[VALUE_WIDTH]),
        .i_neg   (st_neg[VALUE_WIDTH]),
        .o_out   (o_out)
    );
endmodule

FILE: rtl/s2d_dabble_step.sv
// ----------------------------------------------------------------------------
// s2d_dabble_step
// One shift-and-add-3 step of binary to BCD conversion, registered.
// ----------------------------------------------------------------------------
module s2d_dabble_step #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_bin,
    input  logic [4*NDIG-1:0]      i_bcd,
    input  logic                   i_neg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_bin,
    output logic [4*NDIG-1:0]      o_bcd,
    output logic                   o_neg
);
    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_bin;
    logic [4*NDIG-1:0]      r_bcd;
    logic                   r_neg;
    logic [4*NDIG-1:0]      adj;
    logic                   load;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_bcd <= {adj[4*NDIG-2:0], i_bin[VALUE_WIDTH-1]};
            r_bin <= {i_bin[VALUE_WIDTH-2:0], 1'b0};
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;
    assign o_neg   = r_neg;
endmodule

FILE: rtl/s2d_emitter.sv
// ----------------------------------------------------------------------------
// s2d_emitter
// Walks the BCD digits, drops leading zeros and sends the characters out.
// ----------------------------------------------------------------------------
module s2d_emitter #(
    parameter int NDIG = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [4*NDIG-1:0] i_bcd,
    input  logic              i_neg,
    s2d_char_if.source        o_out
);
    localparam int CW = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_SKIP  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [4*NDIG-1:0] r_bcd, n_bcd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    s2d_pkg::t_char    r_char, n_char;
    logic              r_last, n_last;
    logic              can_push;
    logic [3:0]        top_digit;

    assign can_push  = !r_out_valid || o_out.ready;
    assign top_digit = r_bcd[4*NDIG-1 -: 4];
    assign o_ready   = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bcd   = i_bcd;
                    n_cnt   = CW'(NDIG);
                    n_state = i_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (can_push) begin
                    n_out_valid = 1'b1;
                    n_char      = s2d_pkg::ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // keep at least one digit so zero prints as '0'
                if (top_digit == 4'd0 && r_cnt != CW'(1)) begin
                    n_bcd = {r_bcd[4*NDIG-5:0], 4'd0};
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (can_push) begin
                    n_out_valid = 1'b1;
                    n_char      = s2d_pkg::ASCII_ZERO | {2'b00, top_digit};
                    n_last      = (r_cnt == CW'(1));
                    n_bcd       = {r_bcd[4*NDIG-5:0], 4'd0};
                    n_cnt       = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;
endmodule

FILE: dv/tb_s2d_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_s2d_checker
// Watches both channels, predicts the decimal text of each accepted integer
// and compares every character transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_s2d_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2d_value_if.sink   i_in,
    s2d_char_if.sink    i_out,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        s2d_pkg::t_char character;
        logic           last;
    } t_text_char;

    t_text_char text_q[$];

    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] raw);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digs[$];
        t_text_char             c;
        mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
        if (mag == '0) begin
            c.character = s2d_pkg::ASCII_ZERO;
            c.last = 1'b1;
            text_q.push_back(c);
            return;
        end
        while (mag != '0) begin
            digs.push_front(4'(mag % 10));
            mag = mag / 10;
        end
        if (raw[VALUE_WIDTH-1]) begin
            c.character = s2d_pkg::ASCII_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        foreach (digs[i]) begin
            c.character = s2d_pkg::ASCII_ZERO + s2d_pkg::t_char'(digs[i]);
            c.last = (i == digs.size() - 1);
            text_q.push_back(c);
        end
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) predict_text(i_in.value);
            if (i_out.valid && i_out.ready) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected char exp none act %h last %b", $time,
                             i_out.character, i_out.last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = text_q.pop_front();
                    if (want.character !== i_out.character || want.last !== i_out.last) begin
                        $display("%0t: mismatch exp %h/%b act %h/%b", $time,
                                 want.character, want.last, i_out.character, i_out.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= text_q.size();
    end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives integers into the decimal text block, including the extremes, zero
// and small magnitudes, with random gaps and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int VW       = 32;
    localparam int N_RANDOM = 201;
    localparam int LIMIT    = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_errors;
    int   n_pending;
    int   cycles = 0;
    bit   stim_done = 1'b0;

    s2d_value_if #(.VALUE_WIDTH(VW)) in_ch ();
    s2d_char_if                      out_ch ();

    signed_int_to_decimal_ascii_top #(.VALUE_WIDTH(VW)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    tb_s2d_checker #(.VALUE_WIDTH(VW)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch.sink),
        .i_out    (out_ch.sink),
        .o_errors (n_errors),
        .o_pending(n_pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        int            w;
        v = $urandom;
        // mostly trim to a random width so short texts get covered too
        w = $urandom_range(1, VW);
        if ($urandom_range(0, 3) != 0) v = v & VW'((64'd1 << w) - 64'd1);
        if ($urandom_range(0, 1) == 1 && w < VW) v = -v;
        return v;
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_value(input logic [VW-1:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off early on
    initial begin
        int stall;
        @(posedge i_rst_n);
        repeat (30) @(posedge i_clk);
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    logic [VW-1:0] directed[$] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'd999999999, -32'sd999999999, 32'd1234567890, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967
    };

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_value(directed[i]);
        repeat (N_RANDOM) send_value(random_value());
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
